FILE: src/ixh_pkg.sv
// Shared types and constants for the indexed min-heap.
package ixh_pkg;

  localparam int KEY_BITS = 64;
  localparam int TAG_BITS = 10;

  typedef enum logic [1:0] {
    REQ_PUSH     = 2'd0,
    REQ_EXTRACT  = 2'd1,
    REQ_DECREASE = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_ABSENT = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_RED,
    S_DISP,
    S_UP_RD,
    S_UP_CMP,
    S_DK_MAP,
    S_DK_CHK,
    S_DK_TEST,
    S_EX_RD0,
    S_EX_RDL,
    S_EX_TAKE,
    S_SK_RL,
    S_SK_RR,
    S_SK_CMP,
    S_FIN,
    S_RES
  } state_t;

  typedef struct packed {
    logic signed [KEY_BITS-1:0] key;
    logic [TAG_BITS-1:0]        tag;
  } heap_entry_t;

endpackage

FILE: src/indexed_min_heap.sv
// Indexed binary min-heap with decrease-key: sequencer, heap memory and position map.
//
// Usage: drive req_type, key_value and entry_tag and raise start; the request
// transfers at a rising edge where start is high and busy is low. Push (0)
// inserts a key with its tag, extract (1) removes the smallest key, decrease
// (2) rewrites the key of a live tag. Each request gives one result: done is
// high for exactly one cycle with status, min_key and min_tag valid; min_key
// and min_tag are zero unless an entry was extracted. The receiver cannot
// stall, so the result is lost if not captured in that cycle.
// Sequencing: the sequencer walks the tree over the heap memory's one read port.
// Push and decrease climb one level per parent read and compare; extract
// descends one level per left-child read, right-child read and compare. A
// full push, an empty extract or an unused request answers without walking
// the tree. Tags at or above TAG_COUNT are first reduced modulo TAG_COUNT.
// One request is in flight at a time; busy drops in the cycle after the
// result, and the next request can transfer from then on.
// Reset: a sweep clears all TAG_COUNT entries of the position map (1024 by
// default); busy is high during it.
module indexed_min_heap #(
  parameter int HEAP_DEPTH = 256,
  parameter int TAG_COUNT  = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [1:0]                           req_type,
  input  logic signed [ixh_pkg::KEY_BITS-1:0]  key_value,
  input  logic [ixh_pkg::TAG_BITS-1:0]         entry_tag,
  output logic                                 done,
  output logic [1:0]                           status,
  output logic signed [ixh_pkg::KEY_BITS-1:0]  min_key,
  output logic [ixh_pkg::TAG_BITS-1:0]         min_tag
);
  import ixh_pkg::*;

  localparam int SA = $clog2(HEAP_DEPTH);
  localparam int CW = $clog2(HEAP_DEPTH + 1);
  localparam int IW = $clog2(TAG_COUNT);
  localparam int RW = $clog2(TAG_COUNT) + TAG_BITS + 2;
  localparam int LW = SA + 2;

  state_t state, state_next;

  heap_entry_t heap_mem [HEAP_DEPTH];
  heap_entry_t heap_q;
  heap_entry_t lent;

  req_t                       op;
  logic signed [KEY_BITS-1:0] in_key;
  logic [RW-1:0]              red_tag;
  logic [3:0]                 kk;
  logic signed [KEY_BITS-1:0] cur_key;
  logic [TAG_BITS-1:0]        cur_tag;
  logic [SA-1:0]              slot;
  logic [CW-1:0]              count;
  status_t                    res_status;
  logic signed [KEY_BITS-1:0] res_key;
  logic [TAG_BITS-1:0]        res_tag;
  logic                       swapped;
  logic                       m_valid;
  logic [SA-1:0]              m_slot;

  logic [SA-1:0]       heap_rd_addr;
  logic                heap_we;
  logic [SA-1:0]       heap_wr_addr;
  heap_entry_t         heap_wr_data;
  logic [IW-1:0]       map_rd_idx;
  logic                map_we;
  logic [IW-1:0]       map_wr_idx;
  logic                map_wr_valid;
  logic [SA-1:0]       map_wr_slot;
  logic                map_q_valid;
  logic [SA-1:0]       map_q_slot;
  logic                clearing;

  logic [SA-1:0]       par;
  logic [LW-1:0]       lchild;
  logic [LW-1:0]       rchild;
  logic                l_in;
  logic                r_in;
  logic                pick_r;
  heap_entry_t         child;
  logic [SA-1:0]       cslot;
  logic                red_ge;
  logic [TAG_BITS-1:0] tag_r;

  assign par    = SA'((slot - 1'b1) >> 1);
  assign lchild = {1'b0, slot, 1'b1};
  assign rchild = lchild + 1'b1;
  assign l_in   = lchild < LW'(count);
  assign r_in   = rchild < LW'(count);
  assign pick_r = r_in && (heap_q.key < lent.key);
  assign child  = pick_r ? heap_q : lent;
  assign cslot  = pick_r ? rchild[SA-1:0] : lchild[SA-1:0];
  assign red_ge = red_tag >= (RW'(TAG_COUNT) << kk);
  assign tag_r  = TAG_BITS'(red_tag);

  ixh_pos_map #(
    .TAG_COUNT (TAG_COUNT),
    .SLOT_BITS (SA)
  ) u_map (
    .clk      (clk),
    .rst      (rst),
    .rd_idx   (map_rd_idx),
    .rd_valid (map_q_valid),
    .rd_slot  (map_q_slot),
    .wr_en    (map_we),
    .wr_idx   (map_wr_idx),
    .wr_valid (map_wr_valid),
    .wr_slot  (map_wr_slot),
    .clearing (clearing)
  );

  always_ff @(posedge clk) begin
    if (heap_we) begin
      heap_mem[heap_wr_addr] <= heap_wr_data;
    end
    heap_q <= heap_mem[heap_rd_addr];
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start && !clearing) begin
          state_next = (RW'(entry_tag) >= RW'(TAG_COUNT)) ? S_RED : S_DISP;
        end
      end
      S_RED: begin
        if (kk == '0) begin
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        case (op)
          REQ_PUSH:     state_next = (count == CW'(HEAP_DEPTH)) ? S_RES : S_UP_RD;
          REQ_EXTRACT:  state_next = (count == '0) ? S_RES : S_EX_RD0;
          REQ_DECREASE: state_next = S_DK_MAP;
          default:      state_next = S_RES;
        endcase
      end
      S_UP_RD:   state_next = (slot == '0) ? S_FIN : S_UP_CMP;
      S_UP_CMP:  state_next = (cur_key < heap_q.key) ? S_UP_RD : S_FIN;
      S_DK_MAP:  state_next = S_DK_CHK;
      S_DK_CHK:  state_next = S_DK_TEST;
      S_DK_TEST: begin
        if (m_valid && (CW'(m_slot) < count) && (heap_q.tag == tag_r)) begin
          state_next = S_UP_RD;
        end else begin
          state_next = S_RES;
        end
      end
      S_EX_RD0:  state_next = S_EX_RDL;
      S_EX_RDL:  state_next = S_EX_TAKE;
      S_EX_TAKE: state_next = S_SK_RL;
      S_SK_RL:   state_next = l_in ? S_SK_RR : S_FIN;
      S_SK_RR:   state_next = S_SK_CMP;
      S_SK_CMP:  state_next = (cur_key <= child.key) ? S_FIN : S_SK_RL;
      S_FIN:     state_next = S_IDLE;
      S_RES:     state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    heap_rd_addr = '0;
    heap_we      = 1'b0;
    heap_wr_addr = slot;
    heap_wr_data = heap_q;
    map_rd_idx   = IW'(tag_r);
    map_we       = 1'b0;
    map_wr_idx   = IW'(heap_q.tag);
    map_wr_valid = 1'b1;
    map_wr_slot  = slot;
    case (state)
      S_UP_RD:   heap_rd_addr = par;
      S_UP_CMP: begin
        if (cur_key < heap_q.key) begin
          heap_we = 1'b1;
          map_we  = 1'b1;
        end
      end
      S_DK_CHK:  heap_rd_addr = map_q_slot;
      S_EX_RDL:  heap_rd_addr = SA'(count - 1'b1);
      S_EX_TAKE: begin
        map_we       = 1'b1;
        map_wr_idx   = IW'(res_tag);
        map_wr_valid = 1'b0;
      end
      S_SK_RL:   heap_rd_addr = lchild[SA-1:0];
      S_SK_RR:   heap_rd_addr = rchild[SA-1:0];
      S_SK_CMP: begin
        heap_wr_data = child;
        map_wr_idx   = IW'(child.tag);
        if (!(cur_key <= child.key)) begin
          heap_we = 1'b1;
          map_we  = 1'b1;
        end
      end
      S_FIN: begin
        heap_we      = 1'b1;
        heap_wr_data = '{key: cur_key, tag: cur_tag};
        map_wr_idx   = IW'(cur_tag);
        map_we       = !((op == REQ_EXTRACT) && !swapped && (cur_tag == res_tag));
      end
      default: ;
    endcase
  end

  always_comb begin
    busy   = (state != S_IDLE) || clearing;
    done   = (state == S_FIN) || (state == S_RES);
    status = res_status;
    min_key = res_key;
    min_tag = res_tag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_DISP: begin
          if (op == REQ_PUSH && count != CW'(HEAP_DEPTH)) begin
            count <= count + 1'b1;
          end
        end
        S_EX_TAKE: count <= count - 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        op         <= req_t'(req_type);
        in_key     <= key_value;
        red_tag    <= RW'(entry_tag);
        kk         <= 4'(TAG_BITS - 1);
        res_status <= ST_DONE;
        res_key    <= '0;
        res_tag    <= '0;
        swapped    <= 1'b0;
      end
      S_RED: begin
        if (red_ge) begin
          red_tag <= red_tag - (RW'(TAG_COUNT) << kk);
        end
        kk <= kk - 1'b1;
      end
      S_DISP: begin
        cur_key <= in_key;
        cur_tag <= tag_r;
        slot    <= SA'(count);
        case (op)
          REQ_PUSH: begin
            if (count == CW'(HEAP_DEPTH)) begin
              res_status <= ST_FULL;
            end
          end
          REQ_EXTRACT: begin
            if (count == '0) begin
              res_status <= ST_EMPTY;
            end
          end
          default: ;
        endcase
      end
      S_UP_CMP: begin
        if (cur_key < heap_q.key) begin
          slot <= par;
        end
      end
      S_DK_CHK: begin
        m_valid <= map_q_valid;
        m_slot  <= map_q_slot;
      end
      S_DK_TEST: begin
        slot <= m_slot;
        if (!(m_valid && (CW'(m_slot) < count) && (heap_q.tag == tag_r))) begin
          res_status <= ST_ABSENT;
        end
      end
      S_EX_RDL: begin
        res_key <= heap_q.key;
        res_tag <= heap_q.tag;
      end
      S_EX_TAKE: begin
        cur_key <= heap_q.key;
        cur_tag <= heap_q.tag;
        slot    <= '0;
      end
      S_SK_RR:   lent <= heap_q;
      S_SK_CMP: begin
        if (!(cur_key <= child.key)) begin
          slot    <= cslot;
          swapped <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted transfer did not raise busy");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(HEAP_DEPTH))
    else $error("heap count beyond depth");

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy && !clearing)
    else $error("result strobe outside an active request");

  a_busy_fall: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> $past(done) || $past(clearing))
    else $error("busy dropped without a result");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    done && (status != ST_DONE) |-> (min_key == '0) && (min_tag == '0))
    else $error("nonzero payload on a failed request");

endmodule

FILE: src/ixh_pos_map.sv
// Tag-to-slot position map with valid bits and a clearing sweep after reset.
module ixh_pos_map #(
  parameter int TAG_COUNT = 1024,
  parameter int SLOT_BITS = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [$clog2(TAG_COUNT)-1:0] rd_idx,
  output logic                         rd_valid,
  output logic [SLOT_BITS-1:0]         rd_slot,
  input  logic                         wr_en,
  input  logic [$clog2(TAG_COUNT)-1:0] wr_idx,
  input  logic                         wr_valid,
  input  logic [SLOT_BITS-1:0]         wr_slot,
  output logic                         clearing
);

  localparam int IW = $clog2(TAG_COUNT);

  logic [SLOT_BITS:0] mem [TAG_COUNT];
  logic [SLOT_BITS:0] rd_q;
  logic [IW-1:0]      clr_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (clr_cnt == IW'(TAG_COUNT - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_cnt] <= '0;
    end else if (wr_en) begin
      mem[wr_idx] <= {wr_valid, wr_slot};
    end
    rd_q <= mem[rd_idx];
  end

  assign rd_valid = rd_q[SLOT_BITS];
  assign rd_slot  = rd_q[SLOT_BITS-1:0];

endmodule
